### sv/dspm_pkg.sv
// Package for the dot-star pattern matcher: byte codes, register indexes and the
// step bundle handed from the top level to every cell of the row.
// Depends on nothing; every other file of the block but the bound port checks imports it.
`default_nettype none

package dspm_pkg;

   // Pattern metacharacters.
   localparam logic [7:0] STAR_BYTE = 8'h2A;
   localparam logic [7:0] DOT_BYTE  = 8'h2E;

   // Default number of pattern positions.
   localparam int unsigned PATTERN_MAX_DEFAULT = 16;

   // Configuration register indexes and widths.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned LENGTH_W    = 5;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LEN  = 2'd2;

   // Command codes of an input item.
   localparam logic CMD_RESTART = 1'b0;
   localparam logic CMD_APPEND  = 1'b1;

   // What every cell needs to know about the item being taken in this cycle.
   typedef struct packed {
      logic       enable;
      logic       cmd;
      logic [7:0] text_byte;
   } step_type;

   // A pattern byte matches a text byte when equal or when it is the dot.
   function automatic logic byte_fits(input logic [7:0] text_byte,
                                      input logic [7:0] pat_byte);
      return (pat_byte == DOT_BYTE) || (pat_byte == text_byte);
   endfunction

endpackage

`default_nettype wire

### sv/dspm_cell.sv
// One cell of the prefix-match row: holds the row bit for one pattern prefix.
// Depends on dspm_pkg; its neighbours supply the row bit to the left and the
// new value two cells back, which forms the star chain.
`default_nettype none

module dspm_cell
   import dspm_pkg::*;
#(
   parameter int unsigned Pos = 1
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire step_type   step,
   input  wire logic [7:0] byte_self,
   input  wire logic [7:0] byte_prev,
   input  wire logic       row_left,
   input  wire logic       chain_two,
   output logic            next_bit,
   output logic            row_bit
);

   logic is_star;
   logic row_ff;
   logic row_in;

   // A star repeats the byte before it; at the front it is a literal.
   assign is_star = (Pos >= 2) && (byte_self == STAR_BYTE);

   // New row bit for this prefix.
   always_comb begin
      if (step.cmd == CMD_RESTART) begin
         next_bit = is_star && chain_two;
      end else if (is_star) begin
         next_bit = chain_two || (byte_fits(step.text_byte, byte_prev) && row_ff);
      end else begin
         next_bit = byte_fits(step.text_byte, byte_self) && row_left;
      end
   end

   assign row_in = step.enable ? next_bit : row_ff;

   // The row bit is only updated when an item is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= 1'b0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row_bit = row_ff;

endmodule

`default_nettype wire

### sv/dot_star_pattern_matcher_unit.sv
// Top level of the dot-star pattern matcher: configuration registers, the row
// of dspm_cell instances, the length select and a two-entry result buffer.
// Depends on dspm_pkg and dspm_cell.
//
//   Channel  Direction  Handshake            Payload
//   req_     in         req_valid/req_stall  req_cmd, req_text_byte
//   rsp_     out        rsp_valid/rsp_stall  rsp_full_match
//   csr_     in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One item is taken per cycle while req_stall is low; its result is registered
// in the output or skid register. The whole row settles combinationally through
// the star chain, which runs through every second cell of the row.
// Reset clears the row to the empty-text state and the pattern registers to 0.
// A stalled result is held in the output register and one further item is
// caught in a skid register; req_stall rises only when both are full.
`default_nettype none

module dot_star_pattern_matcher_unit
   import dspm_pkg::*;
#(
   parameter int unsigned PatternMax = PATTERN_MAX_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Input items.
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_cmd,
   input  wire logic [7:0]             req_text_byte,
   // Result items.
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_full_match,
   // Configuration writes.
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned IdxW = $clog2(PatternMax + 1);

   logic [CSR_DATA_W-1:0] pat_low_ff;
   logic [CSR_DATA_W-1:0] pat_high_ff;
   logic [LENGTH_W-1:0]   length_ff;
   logic [7:0]            pat_bytes [PatternMax];
   logic [PatternMax:0]   row_bits;
   logic [PatternMax:0]   next_row;
   logic                  row0_ff;
   logic                  row0_in;
   logic [IdxW-1:0]       len_sel;
   logic                  match_now;
   step_type              step;
   logic                  accept;
   logic                  out_take;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic                  out_data_ff;
   logic                  out_data_in;
   logic                  skid_valid_ff;
   logic                  skid_valid_in;
   logic                  skid_data_ff;
   logic                  skid_data_in;

   // Configuration is always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         length_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PATTERN_LOW:  pat_low_ff  <= csr_wdata;
            CSR_PATTERN_HIGH: pat_high_ff <= csr_wdata;
            CSR_PATTERN_LEN:  length_ff   <= csr_wdata[LENGTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Pattern bytes by position; positions past the two registers read as zero.
   for (genvar k = 0; k < PatternMax; k++) begin : g_bytes
      if (k < 8) begin : g_low
         assign pat_bytes[k] = pat_low_ff[8*k +: 8];
      end else if (k < 16) begin : g_high
         assign pat_bytes[k] = pat_high_ff[8*(k-8) +: 8];
      end else begin : g_zero
         assign pat_bytes[k] = 8'h00;
      end
   end

   // Step bundle for the cells.
   assign accept = req_valid && !req_stall;
   assign step   = {accept, req_cmd, req_text_byte};

   // The empty prefix matches only the empty text.
   assign next_row[0] = (req_cmd == CMD_RESTART);
   assign row_bits[0] = row0_ff;
   assign row0_in     = accept ? next_row[0] : row0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_ff <= 1'b1;
      end else begin
         row0_ff <= row0_in;
      end
   end

   // Row of cells, one per pattern prefix.
   for (genvar j = 1; j <= PatternMax; j++) begin : g_cells
      logic [7:0] byte_prev;
      logic       chain_two;
      if (j >= 2) begin : g_link
         assign byte_prev = pat_bytes[j-2];
         assign chain_two = next_row[j-2];
      end else begin : g_first
         assign byte_prev = 8'h00;
         assign chain_two = 1'b0;
      end
      dspm_cell #(
         .Pos(j)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .step     (step),
         .byte_self(pat_bytes[j-1]),
         .byte_prev(byte_prev),
         .row_left (row_bits[j-1]),
         .chain_two(chain_two),
         .next_bit (next_row[j]),
         .row_bit  (row_bits[j])
      );
   end

   // Length saturates at the number of cells.
   always_comb begin
      if (32'(length_ff) > 32'(PatternMax)) begin
         len_sel = IdxW'(PatternMax);
      end else begin
         len_sel = IdxW'(length_ff);
      end
   end

   assign match_now = next_row[len_sel];

   // Output register with a skid register behind it.
   assign out_take  = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_take) begin
         out_valid_in = 1'b0;
      end
      if (skid_valid_ff && out_take) begin
         out_valid_in  = 1'b1;
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end else if (accept) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_data_in  = match_now;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = match_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_full_match = out_data_ff;

endmodule

`default_nettype wire

### sv/dspm_checker.sv
// Port-level checks for the dot-star pattern matcher, bound to its top level.
// Depends only on the handshake and result ports of dot_star_pattern_matcher_unit.
`default_nettype none

module dspm_assertions (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic rsp_full_match
);

   // No result is shown in the first cycle after reset is released.
   a_reset_clears: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   // A stalled result holds until it is taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_full_match))
      else $error("stalled result changed or dropped");

   // The input only stalls when a result is already waiting.
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result waiting");

   // An item taken into an empty block gives its result in the next cycle.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> rsp_valid)
      else $error("result missing one cycle after an item");

endmodule

bind dot_star_pattern_matcher_unit dspm_assertions u_dspm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_full_match(rsp_full_match)
);

`default_nettype wire

### bench/dspm_checker.sv
// Checker for the dot-star pattern matcher: follows the configuration writes, keeps
// its own copy of the prefix-match row and compares every result item in order.
// Depends on dspm_pkg for register indexes, command codes and byte codes.
`timescale 1ns / 100ps

module dspm_checker
   import dspm_pkg::*;
#(
   parameter int unsigned PatternMax = PATTERN_MAX_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire logic                   req_cmd,
   input  wire logic [7:0]             req_text_byte,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire logic                   rsp_full_match,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                          mismatches,
   output int                          awaiting
);

   // Shadow copies of the pattern registers and of the row.
   logic [63:0]         shadow_low;
   logic [63:0]         shadow_high;
   logic [LENGTH_W-1:0] shadow_length;
   logic [PatternMax:0] shadow_row;

   // Expected full_match flags, oldest first.
   logic match_flags[$];
   logic wanted;
   int   results_seen;

   initial begin
      mismatches = 0;
      awaiting   = 0;
   end

   // Pattern byte at a position; positions past the two registers read as zero.
   function automatic logic [7:0] pattern_at(input int unsigned pos);
      if (pos < 8) return shadow_low[8*pos +: 8];
      if (pos < 16) return shadow_high[8*(pos-8) +: 8];
      return 8'h00;
   endfunction

   // Row bit j closes on a star when the pattern byte before it is a star.
   function automatic logic star_closes(input int unsigned j);
      return (j >= 2) && (pattern_at(j - 1) == STAR_BYTE);
   endfunction

   function automatic logic byte_accepts(input logic [7:0] pat, input logic [7:0] txt);
      return (pat == DOT_BYTE) || (pat == txt);
   endfunction

   // Next row for a restart or for one more text byte.
   function automatic logic [PatternMax:0] next_row(input logic cmd,
                                                     input logic [7:0] txt,
                                                     input logic [PatternMax:0] cur);
      logic [PatternMax:0] nxt;
      nxt    = '0;
      nxt[0] = (cmd == CMD_RESTART);
      for (int j = 1; j <= PatternMax; j++) begin
         if (star_closes(j)) begin
            if (cmd == CMD_RESTART)
               nxt[j] = nxt[j-2];
            else
               nxt[j] = nxt[j-2] || (byte_accepts(pattern_at(j - 2), txt) && cur[j]);
         end else if (cmd == CMD_APPEND) begin
            nxt[j] = byte_accepts(pattern_at(j - 1), txt) && cur[j-1];
         end
      end
      return nxt;
   endfunction

   // Row bit that stands for the whole pattern; the length saturates.
   function automatic logic whole_match(input logic [PatternMax:0] row);
      int unsigned used;
      used = (shadow_length > PatternMax) ? PatternMax : shadow_length;
      return row[used];
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches = mismatches + 1;
   endtask

   // Results are compared before new items are taken: a result never shows
   // in the cycle its item is accepted.
   always @(posedge clock) begin
      if (reset) begin
         shadow_low    = '0;
         shadow_high   = '0;
         shadow_length = '0;
         shadow_row    = '0;
         shadow_row[0] = 1'b1;
         results_seen  = 0;
         match_flags.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (match_flags.size() == 0) begin
               report_mismatch($sformatf("result %0d (full_match %b) with no item waiting",
                                         results_seen, rsp_full_match));
            end else begin
               wanted = match_flags.pop_front();
               if (rsp_full_match !== wanted)
                  report_mismatch($sformatf("result %0d full_match %b, predicted %b",
                                            results_seen, rsp_full_match, wanted));
            end
            results_seen++;
         end
         // An item taken at the same edge as a write still sees the old pattern.
         if (req_valid && !req_stall) begin
            shadow_row = next_row(req_cmd, req_text_byte, shadow_row);
            match_flags.push_back(whole_match(shadow_row));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PATTERN_LOW: shadow_low = csr_wdata;
               CSR_PATTERN_HIGH: shadow_high = csr_wdata;
               CSR_PATTERN_LEN: shadow_length = csr_wdata[LENGTH_W-1:0];
               default: ;
            endcase
         end
      end
      awaiting <= match_flags.size();
   end

endmodule

### bench/tb.sv
// Testbench top for dot_star_pattern_matcher_unit: clock, reset, pattern writes,
// text items with random idling, and the verdict from the checker's count.
// Depends on dspm_pkg, dspm_checker and the block's RTL.
`timescale 1ns / 100ps

module tb;
   import dspm_pkg::*;

   typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_level_type;

   localparam logic [7:0] LETTER_A = 8'h61;
   localparam int ITEM_TARGET = 1650;
   localparam int CALM_TAIL   = 160;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_cmd = CMD_RESTART;
   logic [7:0]             req_text_byte = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_full_match;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_PATTERN_LOW;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int             mismatches;
   int             awaiting;
   idle_level_type idle_level = IDLE_NONE;
   int             items_sent = 0;
   int unsigned    stall_left = 0;

   // Current pattern as bytes, for building texts that follow it.
   logic [7:0] pat_bytes[16];
   int         pat_count;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   dot_star_pattern_matcher_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_text_byte  (req_text_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_full_match (rsp_full_match),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   dspm_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_text_byte  (req_text_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_full_match (rsp_full_match),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .awaiting       (awaiting)
   );

   // Result side stalls in bursts whose length is drawn into stall_left; none at IDLE_NONE.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (idle_level != IDLE_NONE &&
                   $urandom_range(0, idle_level == IDLE_HEAVY ? 3 : 11) == 0) begin
         stall_left <= $urandom_range(0, 15);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Offer one item, perhaps after a gap, and hold it until it is taken.
   task automatic send_item(input logic cmd, input logic [7:0] text);
      if (idle_level != IDLE_NONE &&
          $urandom_range(0, idle_level == IDLE_HEAVY ? 3 : 11) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_text_byte <= text;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Stop offering items and wait until every result has come back.
   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
   endtask

   // Write all three pattern registers in one burst; the block must be idle.
   task automatic write_pattern(input logic [63:0] low_bytes, input logic [63:0] high_bytes,
                                input logic [LENGTH_W-1:0] length);
      csr_valid <= 1'b1;
      csr_index <= CSR_PATTERN_LOW;
      csr_wdata <= low_bytes;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_PATTERN_HIGH;
      csr_wdata <= high_bytes;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_PATTERN_LEN;
      csr_wdata <= CSR_DATA_W'(length);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Random pattern: mostly letters, dots and stars, sometimes raw noise.
   task automatic make_pattern;
      logic [7:0]  pick;
      logic [63:0] low_bytes;
      logic [63:0] high_bytes;
      for (int i = 0; i < 16; i++) pat_bytes[i] = 8'($urandom);
      pat_count = 0;
      if ($urandom_range(0, 9) == 0) begin
         pat_count = $urandom_range(0, 16);
      end else begin
         // A star at the front is a literal star byte.
         if ($urandom_range(0, 7) == 0) pat_bytes[pat_count++] = STAR_BYTE;
         while (pat_count < 16 && $urandom_range(0, 6) != 0) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: pick = LETTER_A + 8'($urandom_range(0, 2));
               6, 7: pick = DOT_BYTE;
               8: pick = STAR_BYTE;
               default: pick = 8'($urandom);
            endcase
            pat_bytes[pat_count++] = pick;
            if (pat_count < 16 && $urandom_range(0, 2) == 0) pat_bytes[pat_count++] = STAR_BYTE;
         end
      end
      for (int i = 0; i < 8; i++) begin
         low_bytes[8*i +: 8]  = pat_bytes[i];
         high_bytes[8*i +: 8] = pat_bytes[i+8];
      end
      write_pattern(low_bytes, high_bytes, LENGTH_W'(pat_count));
   endtask

   // Text that walks the pattern, starred items repeated 0 to 3 times, with
   // the odd wrong byte or trailing byte so that misses show up as well.
   task automatic send_text;
      int         pos;
      int         reps;
      logic       starred;
      logic [7:0] want;
      if ($urandom_range(0, 4) != 0) send_item(CMD_RESTART, 8'($urandom));
      pos = 0;
      while (pos < pat_count) begin
         starred = (pos + 1 < pat_count) && (pat_bytes[pos+1] == STAR_BYTE);
         reps    = starred ? $urandom_range(0, 3) : 1;
         repeat (reps) begin
            want = (pat_bytes[pos] == DOT_BYTE) ? 8'($urandom) : pat_bytes[pos];
            if ($urandom_range(0, 24) == 0) want = 8'($urandom);
            send_item(CMD_APPEND, want);
         end
         pos += starred ? 2 : 1;
         // Now and then the text is cut short by a restart.
         if ($urandom_range(0, 39) == 0) send_item(CMD_RESTART, 8'($urandom));
      end
      repeat ($urandom_range(0, 2))
         send_item(CMD_APPEND, $urandom_range(0, 1) ? LETTER_A + 8'($urandom_range(0, 2))
                                                  : 8'($urandom));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset state: empty pattern, all-zero and all-one bytes.
      idle_level = IDLE_LIGHT;
      send_item(CMD_RESTART, 8'hFF);
      send_item(CMD_APPEND, 8'h00);
      send_item(CMD_APPEND, 8'hFF);
      drain();

      // Leading star as a literal, star after star, dot: "*a**.b".
      write_pattern(64'h0000_622E_2A2A_612A, 64'h0, 5'd6);
      send_item(CMD_RESTART, 8'h00);
      send_item(CMD_APPEND, STAR_BYTE);
      send_item(CMD_APPEND, LETTER_A);
      send_item(CMD_APPEND, LETTER_A);
      send_item(CMD_APPEND, STAR_BYTE);
      send_item(CMD_APPEND, 8'h5A);
      send_item(CMD_APPEND, LETTER_A + 8'd1);
      drain();

      // Dot-star chains then eight 0xFF bytes; length past the top saturates.
      write_pattern(64'h2A2E_2A2E_2A2E_2A2E, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31);
      send_item(CMD_RESTART, 8'h00);
      repeat (8) send_item(CMD_APPEND, 8'hFF);
      drain();

      // A new length takes effect on the row without a restart.
      write_pattern(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd17);
      send_item(CMD_APPEND, 8'hFF);
      drain();
      write_pattern(64'h0, 64'h0, 5'd0);
      send_item(CMD_APPEND, 8'h00);
      send_item(CMD_RESTART, 8'h00);
      drain();

      // Random phases: a new pattern each time, several texts per pattern.
      while (items_sent < ITEM_TARGET) begin
         make_pattern();
         if (items_sent >= ITEM_TARGET - CALM_TAIL)
            idle_level = IDLE_NONE;
         else
            idle_level = idle_level_type'($urandom_range(0, 4) == 0 ? IDLE_NONE
                                          : $urandom_range(IDLE_LIGHT, IDLE_HEAVY));
         repeat ($urandom_range(2, 6)) begin
            send_text();
            if ($urandom_range(0, 9) == 0) drain();
         end
         drain();
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("tb failed");
      $finish;
   end

endmodule
